@@ design/dictionary_prefix_substituter_assert.svh @@
// Assertion macros for the prefix substituter
`ifndef DICTIONARY_PREFIX_SUBSTITUTER_ASSERT_SVH
`define DICTIONARY_PREFIX_SUBSTITUTER_ASSERT_SVH
// implication, disabled during reset
`define DPS_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("assertion failed");
// next-cycle implication, disabled during reset
`define DPS_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("assertion failed");
`endif

@@ design/dps_pkg.sv @@
//------------------------------------------------------------------------------
// dps_pkg
// Shared types and constants of the prefix substituter.
//------------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
package dps_pkg;
	typedef enum logic [1:0] {
		FUNC_TEXT  = 2'd0,
		FUNC_WRITE = 2'd1,
		FUNC_FLUSH = 2'd2,
		FUNC_NONE  = 2'd3
	} func_t;

	localparam logic [7:0] DOLLAR     = 8'd36;
	localparam logic [7:0] DOLLAR_SUB = 8'd225;
	localparam logic [7:0] ASCII_ZERO = 8'd48;

	typedef struct packed {
		logic [1:0] func;
		logic [7:0] data_byte;
		logic [7:0] entry_index;
		logic [3:0] char_position;
	} req_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       last_of_run;
		logic       word_overflow;
	} rsp_t;

	// best-so-far record carried from cell to cell
	typedef struct packed {
		logic        active;
		logic [6:0]  best_len;
		logic [9:0]  best_idx;
	} scan_t;

	function automatic logic is_ws(input logic [7:0] b);
		return (b >= 8'd9 && b <= 8'd13) || b == 8'd32;
	endfunction
endpackage
`default_nettype wire

@@ design/dps_if.sv @@
//------------------------------------------------------------------------------
// dps_if
// Valid/ready channel carrying one payload.
//------------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
interface dps_if #(parameter type T = logic) ();
	logic valid;
	logic ready;
	T     payload;
	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface
`default_nettype wire

@@ design/dps_cell.sv @@
//------------------------------------------------------------------------------
// dps_cell
// One scan cell: compares its share of the key table against the word.
//------------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module dps_cell #(
	parameter int KEY_BYTES = 16,
	parameter int MAX_WORD  = 32,
	parameter int DEPTH     = 16,
	parameter int BASE      = 0
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         wr_en,
	input  wire logic [$clog2(DEPTH)-1:0]     wr_row,
	input  wire logic [$clog2(KEY_BYTES)-1:0] wr_pos,
	input  wire logic [7:0]                   wr_byte,
	input  wire logic [$clog2(DEPTH)-1:0]     rd_row,
	input  wire logic [MAX_WORD*8-1:0]        word,
	input  wire logic [6:0]                   word_len,
	input  wire dps_pkg::scan_t               scan_in,
	output dps_pkg::scan_t                    scan_out
);
	import dps_pkg::*;
	localparam int RB = $clog2(DEPTH);

	logic [KEY_BYTES*8-1:0] mem [DEPTH];
	logic [KEY_BYTES*8-1:0] key_q;
	logic [RB-1:0]          row_q;
	logic [DEPTH-1:0]       valid_q;
	logic                   key_valid_q;
	scan_t                  scan_q;
	logic [6:0]             klen;
	logic                   hit;
	logic [KEY_BYTES*8-1:0] wmask;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_row] <= (valid_q[wr_row] ? mem[wr_row] : '0) & ~wmask
				| ({{(KEY_BYTES*8-8){1'b0}}, wr_byte} << {wr_pos, 3'b000});
		end
		key_q <= mem[rd_row];
		row_q <= rd_row;
	end

	assign wmask = {{(KEY_BYTES*8-8){1'b0}}, 8'hFF} << {wr_pos, 3'b000};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q     <= '0;
			key_valid_q <= 1'b0;
			scan_q      <= '0;
		end else begin
			if (wr_en) valid_q[wr_row] <= 1'b1;
			key_valid_q <= valid_q[rd_row];
			scan_q <= scan_in;
		end
	end

	always_comb begin
		klen = 7'(KEY_BYTES);
		for (int k = KEY_BYTES - 1; k >= 0; k--) begin
			if (key_q[k*8 +: 8] == 8'd0) klen = 7'(k);
		end
		if (!key_valid_q) klen = '0;
		hit = klen != 0 && klen <= word_len && klen > scan_q.best_len;
		for (int k = 0; k < KEY_BYTES; k++) begin
			if (k < MAX_WORD && 7'(k) < klen && word[k*8 +: 8] != key_q[k*8 +: 8]) hit = 1'b0;
			if (k >= MAX_WORD && 7'(k) < klen) hit = 1'b0;
		end
	end

	always_comb begin
		scan_out = scan_q;
		if (scan_q.active && hit) begin
			scan_out.best_len = klen;
			scan_out.best_idx = 10'(BASE) + 10'(row_q) + 10'd1;
		end
	end
endmodule
`default_nettype wire

@@ design/dictionary_prefix_substituter.sv @@
//------------------------------------------------------------------------------
// dictionary_prefix_substituter
// Rewrites words of a byte stream against a keyword table.
//------------------------------------------------------------------------------
// Text bytes gather into a word buffer; a flush (whitespace or end of stream)
// runs the word past a row of NCELL scan cells, each owning SCAN key entries
// in its own memory. Cell c reads row tick - c, so the best match of one row
// is handed from cell to cell, and the best over all rows is kept at the end
// of the row. After the scan of a nonempty word, the output gives one byte
// per cycle while it is taken. Non-whitespace text bytes, table writes and
// an empty end-of-stream flush leave the block in its idle state. The key
// table is held in per-entry valid bits, so no clearing pass is needed after
// reset.
`timescale 1ns / 1ps
`default_nettype none
module dictionary_prefix_substituter #(
	parameter int TABLE_ENTRIES = 255,
	parameter int KEY_BYTES     = 16,
	parameter int MAX_WORD      = 32
) (
	input  wire logic clk,
	input  wire logic arst_n,
	dps_if.sink       in_req,
	dps_if.source     out_rsp
);
	import dps_pkg::*;
	localparam int NCELL = 16;
	localparam int ROWS  = (TABLE_ENTRIES + NCELL - 1) / NCELL;
	localparam int RB    = (ROWS > 1) ? $clog2(ROWS) : 1;
	localparam int SCAN  = 1 << RB;
	localparam int PB    = $clog2(KEY_BYTES);
	localparam int WB    = $clog2(MAX_WORD);

	typedef enum logic [2:0] {S_IDLE, S_SCAN, S_DIG, S_WORD, S_WS} state_t;

	state_t              state_q;
	logic [7:0]          word_q [MAX_WORD];
	logic [MAX_WORD*8-1:0] word_flat;
	logic [6:0]          len_q;
	logic                ovf_q;
	logic                ws_q;
	logic [7:0]          ws_byte_q;
	logic [7:0]          tick_q;
	logic [6:0]          acc_len_q;
	logic [9:0]          acc_idx_q;
	logic [6:0]          pos_q;
	logic [3:0]          dig_q [4];
	logic [2:0]          nd_q;
	logic [2:0]          di_q;
	rsp_t                rsp_q;
	logic                ov_q;
	scan_t               chain [NCELL+1];
	req_t                req;
	logic                acc;
	logic [9:0]          eidx;
	logic                wr_ok;
	logic                take;
	logic                emit;
	logic [17:0]         q1_full;
	logic [15:0]         q2_full;
	logic [6:0]          q1;
	logic [3:0]          q2;
	logic [9:0]          r0;
	logic [6:0]          r1;

	assign req = in_req.payload;
	assign acc = in_req.valid && in_req.ready;
	assign in_req.ready = state_q == S_IDLE && !(ov_q && !out_rsp.ready);
	assign out_rsp.valid = ov_q;
	assign out_rsp.payload = rsp_q;
	assign eidx = {2'b00, req.entry_index} - 10'd1;
	assign wr_ok = req.entry_index != 8'd0 && 32'(req.entry_index) <= TABLE_ENTRIES
		&& 32'(req.char_position) < KEY_BYTES;

	assign take = chain[NCELL].active && chain[NCELL].best_len != 7'd0
		&& (chain[NCELL].best_len > acc_len_q
		|| (chain[NCELL].best_len == acc_len_q && chain[NCELL].best_idx < acc_idx_q));
	assign emit = (state_q == S_DIG || state_q == S_WORD || state_q == S_WS)
		&& (!ov_q || out_rsp.ready);

	assign q1_full = 18'(acc_idx_q) * 18'd205;
	assign q2_full = 16'(acc_idx_q) * 16'd41;
	assign q1 = q1_full[17:11];
	assign q2 = q2_full[15:12];
	assign r0 = acc_idx_q - 10'(q1) * 10'd10;
	assign r1 = q1 - 7'(q2) * 7'd10;

	always_comb begin
		for (int i = 0; i < MAX_WORD; i++) word_flat[i*8 +: 8] = word_q[i];
	end

	assign chain[0] = '{active: state_q == S_SCAN && 32'(tick_q) < SCAN, best_len: '0,
		best_idx: '0};

	for (genvar c = 0; c < NCELL; c++) begin : g_cell
		scan_t si;
		always_comb begin
			si = chain[c];
			si.active = chain[c].active;
		end
		dps_cell #(.KEY_BYTES(KEY_BYTES), .MAX_WORD(MAX_WORD), .DEPTH(1 << RB),
			.BASE(c * (1 << RB))) u_cell (
			.clk(clk), .arst_n(arst_n),
			.wr_en(acc && func_t'(req.func) == FUNC_WRITE && wr_ok
				&& 32'(eidx) / (1 << RB) == c),
			.wr_row(eidx[RB-1:0]),
			.wr_pos(PB'(req.char_position)),
			.wr_byte(req.data_byte),
			.rd_row(RB'(32'(tick_q) - c)),
			.word(word_flat), .word_len(len_q),
			.scan_in(si), .scan_out(chain[c+1]));
	end

	always_ff @(posedge clk) begin
		if (acc && func_t'(req.func) == FUNC_TEXT && !is_ws(req.data_byte)
			&& len_q < 7'(MAX_WORD))
			word_q[len_q[WB-1:0]] <= (req.data_byte == DOLLAR) ? DOLLAR_SUB : req.data_byte;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE; len_q <= '0; ovf_q <= 1'b0; ws_q <= 1'b0;
			ws_byte_q <= '0; tick_q <= '0; acc_len_q <= '0; acc_idx_q <= '0;
			pos_q <= '0; nd_q <= '0; di_q <= '0; rsp_q <= '0; ov_q <= 1'b0;
			for (int i = 0; i < 4; i++) dig_q[i] <= '0;
		end else begin
			if (ov_q && out_rsp.ready && !emit) ov_q <= 1'b0;
			unique case (state_q)
				S_IDLE: if (acc) begin
					unique case (func_t'(req.func))
						FUNC_TEXT: if (is_ws(req.data_byte)) begin
							ws_q <= 1'b1; ws_byte_q <= req.data_byte;
							tick_q <= '0; acc_len_q <= '0; acc_idx_q <= '0;
							state_q <= (len_q != 0) ? S_SCAN : S_WS;
						end else if (len_q < 7'(MAX_WORD)) len_q <= len_q + 7'd1;
						else ovf_q <= 1'b1;
						FUNC_FLUSH: begin
							ws_q <= 1'b0; tick_q <= '0; acc_len_q <= '0; acc_idx_q <= '0;
							if (len_q != 0) state_q <= S_SCAN;
							else ovf_q <= 1'b0;
						end
						FUNC_WRITE, FUNC_NONE: ;
					endcase
				end
				S_SCAN: begin
					tick_q <= tick_q + 8'd1;
					if (take) begin
						acc_len_q <= chain[NCELL].best_len;
						acc_idx_q <= chain[NCELL].best_idx;
					end
					if (32'(tick_q) == SCAN + NCELL) begin
						pos_q <= acc_len_q;
						nd_q <= (acc_idx_q >= 10'd100) ? 3'd3
							: (acc_idx_q >= 10'd10) ? 3'd2 : 3'd1;
						dig_q[0] <= r0[3:0];
						dig_q[1] <= r1[3:0];
						dig_q[2] <= q2;
						di_q <= 3'd0;
						state_q <= (acc_len_q != 7'd0) ? S_DIG : S_WORD;
					end
				end
				S_DIG: if (!ov_q || out_rsp.ready) begin
					ov_q <= 1'b1;
					rsp_q.word_overflow <= ovf_q;
					rsp_q.last_of_run <= di_q == nd_q && pos_q >= len_q && !ws_q;
					if (di_q == 3'd0) rsp_q.out_byte <= DOLLAR;
					else rsp_q.out_byte <= ASCII_ZERO + 8'(dig_q[2'(nd_q - di_q)]);
					if (di_q == nd_q) begin
						if (pos_q >= len_q) begin
							state_q <= ws_q ? S_WS : S_IDLE;
							len_q <= '0; if (!ws_q) ovf_q <= 1'b0;
						end else state_q <= S_WORD;
					end
					di_q <= di_q + 3'd1;
				end
				S_WORD: if (!ov_q || out_rsp.ready) begin
					ov_q <= 1'b1;
					rsp_q.word_overflow <= ovf_q;
					rsp_q.out_byte <= word_q[pos_q[WB-1:0]];
					rsp_q.last_of_run <= pos_q + 7'd1 >= len_q && !ws_q;
					pos_q <= pos_q + 7'd1;
					if (pos_q + 7'd1 >= len_q) begin
						state_q <= ws_q ? S_WS : S_IDLE;
						len_q <= '0; if (!ws_q) ovf_q <= 1'b0;
					end
				end
				S_WS: if (!ov_q || out_rsp.ready) begin
					ov_q <= 1'b1;
					rsp_q <= '{out_byte: ws_byte_q, last_of_run: 1'b1, word_overflow: 1'b0};
					len_q <= '0; ovf_q <= 1'b0;
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule
`default_nettype wire

@@ design/dps_checker.sv @@
//------------------------------------------------------------------------------
// dps_checker
// Port-level checks of the prefix substituter.
//------------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "dictionary_prefix_substituter_assert.svh"
module dps_checker (
	input wire logic             clk,
	input wire logic             arst_n,
	input wire logic             in_valid,
	input wire logic             in_ready,
	input wire logic             out_valid,
	input wire logic             out_ready,
	input wire dps_pkg::rsp_t    out_payload
);
	import dps_pkg::*;
	`DPS_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_payload))
	`DPS_ASSERT_IMP(a_ws_no_ovf, out_valid && is_ws(out_payload.out_byte) && out_payload.last_of_run, !out_payload.word_overflow)
	`DPS_ASSERT_IMP(a_no_take_stall, in_ready, !(out_valid && !out_ready))
endmodule
bind dictionary_prefix_substituter dps_checker u_chk (
	.clk(clk), .arst_n(arst_n), .in_valid(in_req.valid), .in_ready(in_req.ready),
	.out_valid(out_rsp.valid), .out_ready(out_rsp.ready), .out_payload(out_rsp.payload));
`default_nettype wire
